@@ rtl/core/sqi_pkg.sv @@
package sqi_pkg;

   localparam int DIV_BITS = 31;

   typedef logic [31:0] word_type;
   typedef logic [2:0][31:0] vec3_type;
   typedef logic [3:0][2:0][31:0] quad_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_CHECK = 1'b1
   } func_type;

   typedef enum logic {
      CSR_MAX_TIME     = 1'b0,
      CSR_CONTACT_BAND = 1'b1
   } csr_index_type;

   localparam logic [30:0] MAX_TIME_RESET     = 31'd1092;
   localparam logic [15:0] CONTACT_BAND_RESET = 16'd512;

   // payload that rides along the divider
   typedef struct packed {
      logic     ok;
      vec3_type pos;
      vec3_type vel;
      quad_type vtx;
   } carry_type;

   typedef struct packed {
      logic          sat;
      word_type      md;
      logic [31:0]   rem;
      logic [30:0]   quo;
      logic [30:0]   bits;
   } div_type;

   // 16.16 product, floor, low 32 bits kept
   function automatic word_type fmul(word_type a, word_type b);
      logic signed [63:0] p;
      p = signed'(a) * signed'(b);
      return p[47:16];
   endfunction

   function automatic word_type mag(word_type a);
      return a[31] ? (32'd0 - a) : a;
   endfunction

endpackage

@@ rtl/core/sqi_if.sv @@
interface sqi_req_if;
   import sqi_pkg::*;
   logic               valid;
   logic               ready;
   func_type           func;
   logic [2:0]         plane_index;
   logic [3:0]         word_index;
   logic signed [31:0] word_value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] next_x;
   logic signed [31:0] next_y;
   logic signed [31:0] next_z;
   modport source(output valid, func, plane_index, word_index, word_value,
                  pos_x, pos_y, pos_z, next_x, next_y, next_z, input ready);
   modport sink(input valid, func, plane_index, word_index, word_value,
                pos_x, pos_y, pos_z, next_x, next_y, next_z, output ready);
endinterface

interface sqi_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic               projected;
   logic signed [31:0] proj_x;
   logic signed [31:0] proj_y;
   logic signed [31:0] proj_z;
   logic [30:0]        time_to_hit;
   modport source(output valid, hit, projected, proj_x, proj_y, proj_z, time_to_hit,
                  input ready);
   modport sink(input valid, hit, projected, proj_x, proj_y, proj_z, time_to_hit,
                output ready);
endinterface

interface sqi_csr_if;
   import sqi_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [31:0]   data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/segment_quad_intersect.sv @@
// channel   | dir | handshake     | carries
// req_bus   | in  | valid/ready   | func, plane_index, word_index, word_value, pos, next
// rsp_bus   | out | valid/ready   | hit, projected, proj_x/y/z, time_to_hit
// csr_bus   | in  | valid/ready   | index (max_time, contact_band), data
//
// one item per cycle sustained while the output is taken.
// the depth is set by the 31-stage restoring divider, one quotient bit per stage.
// reset clears stage valids and the two registers; the quad store keeps its contents.
// each stage holds while it and the stages after it are full and the output is not taken,
// so bubbles close up and nothing is dropped or repeated.
module segment_quad_intersect #(
   parameter int PLANE_COUNT = 8
) (
   input logic clock,
   input logic reset,
   sqi_req_if.sink   req_bus,
   sqi_rsp_if.source rsp_bus,
   sqi_csr_if.sink   csr_bus
);
   import sqi_pkg::*;

   localparam int PLANE_AW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam logic [8:0] PLANE_LIMIT = 9'(PLANE_COUNT);

   localparam int ST_IN    = 1;
   localparam int ST_DIFF  = 2;
   localparam int ST_PROD  = 3;
   localparam int ST_SUM   = 4;
   localparam int ST_SIDE  = 5;
   localparam int ST_PRE   = 6;
   localparam int ST_CLAMP = ST_PRE + DIV_BITS + 1;
   localparam int ST_TMUL  = ST_CLAMP + 1;
   localparam int ST_PROJ  = ST_TMUL + 1;
   localparam int ST_DELTA = ST_PROJ + 1;
   localparam int ST_CROSS = ST_DELTA + 1;
   localparam int ST_EDGE  = ST_CROSS + 1;
   localparam int ST_DOT   = ST_EDGE + 1;
   localparam int ST_OUT   = ST_DOT + 1;
   localparam int NS       = ST_OUT;

   // configuration
   logic [30:0] max_time_ff;
   logic [15:0] band_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_time_ff <= MAX_TIME_RESET;
         band_ff     <= CONTACT_BAND_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MAX_TIME:     max_time_ff <= csr_bus.data[30:0];
            CSR_CONTACT_BAND: band_ff     <= csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   // stage valids and enables
   logic [NS:1] v_ff;
   logic [NS:1] v_in;
   logic [NS:1] en;

   generate
      for (genvar k = 1; k <= NS; k++) begin : g_en
         assign en[k] = rsp_bus.ready | ~(&v_ff[NS:k]);
      end
   endgenerate

   assign v_in = {v_ff[NS-1:1], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & v_in) | (~en & v_ff);
      end
   end

   assign req_bus.ready = en[ST_IN];

   // quad store, one ram per word
   logic [8:0]          pidx_ext;
   logic                in_range;
   logic [PLANE_AW-1:0] paddr;
   word_type            rd_word [16];

   assign pidx_ext = 9'(req_bus.plane_index);
   assign in_range = pidx_ext < PLANE_LIMIT;
   assign paddr    = pidx_ext[PLANE_AW-1:0];

   generate
      for (genvar w = 0; w < 16; w++) begin : g_ram
         sqi_ram #(.WIDTH(32), .DEPTH(PLANE_COUNT)) u_ram (
            .clock   (clock),
            .wr_en   (req_bus.valid & en[ST_IN] & (req_bus.func == FUNC_LOAD) & in_range
                      & (req_bus.word_index == 4'(w))),
            .wr_addr (paddr),
            .wr_data (req_bus.word_value),
            .rd_en   (en[ST_IN]),
            .rd_addr (paddr),
            .rd_data (rd_word[w])
         );
      end
   endgenerate

   // stage 1: inputs
   logic     s1_ok_ff;
   vec3_type s1_pos_ff, s1_nxt_ff;

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         s1_ok_ff  <= (req_bus.func == FUNC_CHECK) & in_range;
         s1_pos_ff <= {req_bus.pos_z, req_bus.pos_y, req_bus.pos_x};
         s1_nxt_ff <= {req_bus.next_z, req_bus.next_y, req_bus.next_x};
      end
   end

   quad_type s1_vtx;
   vec3_type s1_n;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            s1_vtx[k][i] = rd_word[k*3+i];
         end
      end
      for (int i = 0; i < 3; i++) begin
         s1_n[i] = rd_word[12+i];
      end
   end

   // stage 2: differences
   logic     s2_ok_ff;
   vec3_type s2_pos_ff, s2_n_ff, s2_rp_ff, s2_rn_ff, s2_vel_ff;
   vec3_type s2_rp_in, s2_rn_in, s2_vel_in;
   word_type s2_off_ff;
   quad_type s2_vtx_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_rp_in[i]  = s1_pos_ff[i] - s1_vtx[0][i];
         s2_rn_in[i]  = s1_nxt_ff[i] - s1_vtx[0][i];
         s2_vel_in[i] = s1_nxt_ff[i] - s1_pos_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DIFF]) begin
         s2_ok_ff  <= s1_ok_ff;
         s2_pos_ff <= s1_pos_ff;
         s2_n_ff   <= s1_n;
         s2_off_ff <= rd_word[15];
         s2_vtx_ff <= s1_vtx;
         s2_rp_ff  <= s2_rp_in;
         s2_rn_ff  <= s2_rn_in;
         s2_vel_ff <= s2_vel_in;
      end
   end

   // stage 3: products with the normal
   logic     s3_ok_ff;
   vec3_type s3_pa_ff, s3_pb_ff, s3_pp_ff, s3_pv_ff;
   vec3_type s3_pa_in, s3_pb_in, s3_pp_in, s3_pv_in;
   vec3_type s3_pos_ff, s3_vel_ff;
   word_type s3_off_ff;
   quad_type s3_vtx_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_pa_in[i] = fmul(s2_rp_ff[i], s2_n_ff[i]);
         s3_pb_in[i] = fmul(s2_rn_ff[i], s2_n_ff[i]);
         s3_pp_in[i] = fmul(s2_pos_ff[i], s2_n_ff[i]);
         s3_pv_in[i] = fmul(s2_vel_ff[i], s2_n_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         s3_ok_ff  <= s2_ok_ff;
         s3_pa_ff  <= s3_pa_in;
         s3_pb_ff  <= s3_pb_in;
         s3_pp_ff  <= s3_pp_in;
         s3_pv_ff  <= s3_pv_in;
         s3_pos_ff <= s2_pos_ff;
         s3_vel_ff <= s2_vel_ff;
         s3_off_ff <= s2_off_ff;
         s3_vtx_ff <= s2_vtx_ff;
      end
   end

   // stage 4: dot product sums
   logic     s4_ok_ff;
   word_type s4_a_ff, s4_b_ff, s4_dvd_ff, s4_dvs_ff;
   vec3_type s4_pos_ff, s4_vel_ff;
   quad_type s4_vtx_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         s4_ok_ff  <= s3_ok_ff;
         s4_a_ff   <= s3_pa_ff[0] + s3_pa_ff[1] + s3_pa_ff[2];
         s4_b_ff   <= s3_pb_ff[0] + s3_pb_ff[1] + s3_pb_ff[2];
         s4_dvd_ff <= 32'd0 - (s3_pp_ff[0] + s3_pp_ff[1] + s3_pp_ff[2] + s3_off_ff);
         s4_dvs_ff <= s3_pv_ff[0] + s3_pv_ff[1] + s3_pv_ff[2];
         s4_pos_ff <= s3_pos_ff;
         s4_vel_ff <= s3_vel_ff;
         s4_vtx_ff <= s3_vtx_ff;
      end
   end

   // stage 5: side tests and magnitudes
   word_type  am, bm, band_ext;
   logic      side_rej;
   carry_type s5_car_ff;
   word_type  s5_mn_ff, s5_md_ff;

   always_comb begin
      am       = mag(s4_a_ff);
      bm       = mag(s4_b_ff);
      band_ext = {16'd0, band_ff};
      side_rej = ((am > band_ext) && (bm > band_ext) && (s4_a_ff[31] == s4_b_ff[31]))
               || ((am < band_ext) && !s4_b_ff[31] && (bm > band_ext));
   end

   always_ff @(posedge clock) begin
      if (en[ST_SIDE]) begin
         s5_car_ff.ok  <= s4_ok_ff & ~side_rej;
         s5_car_ff.pos <= s4_pos_ff;
         s5_car_ff.vel <= s4_vel_ff;
         s5_car_ff.vtx <= s4_vtx_ff;
         s5_mn_ff      <= mag(s4_dvd_ff);
         s5_md_ff      <= mag(s4_dvs_ff);
      end
   end

   // stage 6 and divider: quotient of (mn << 16) / md, saturating past 31 bits
   carry_type car_ff [DIV_BITS+1];
   div_type   div_ff [DIV_BITS+1];
   div_type   div_pre_in;

   always_comb begin
      div_pre_in.sat  = {15'd0, s5_mn_ff} >= {s5_md_ff, 15'd0};
      div_pre_in.md   = s5_md_ff;
      div_pre_in.rem  = {15'd0, s5_mn_ff[31:15]};
      div_pre_in.quo  = '0;
      div_pre_in.bits = {s5_mn_ff[14:0], 16'd0};
   end

   always_ff @(posedge clock) begin
      if (en[ST_PRE]) begin
         car_ff[0] <= s5_car_ff;
         div_ff[0] <= div_pre_in;
      end
   end

   generate
      for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
         logic [32:0] trial;
         logic [32:0] diff;
         div_type     nxt_in;

         always_comb begin
            trial           = {div_ff[j].rem, div_ff[j].bits[DIV_BITS-1-j]};
            diff            = trial - {1'b0, div_ff[j].md};
            nxt_in          = div_ff[j];
            nxt_in.rem      = diff[32] ? trial[31:0] : diff[31:0];
            nxt_in.quo[DIV_BITS-1-j] = ~diff[32];
         end

         always_ff @(posedge clock) begin
            if (en[ST_PRE+1+j]) begin
               car_ff[j+1] <= car_ff[j];
               div_ff[j+1] <= nxt_in;
            end
         end
      end
   endgenerate

   // clamp time
   logic        cl_ok_ff;
   logic [30:0] cl_t_ff;
   vec3_type    cl_pos_ff, cl_vel_ff;
   quad_type    cl_vtx_ff;
   div_type     div_last;

   assign div_last = div_ff[DIV_BITS];

   always_ff @(posedge clock) begin
      if (en[ST_CLAMP]) begin
         cl_ok_ff  <= car_ff[DIV_BITS].ok;
         cl_t_ff   <= (div_last.sat || (div_last.quo > max_time_ff)) ? max_time_ff
                                                                    : div_last.quo;
         cl_pos_ff <= car_ff[DIV_BITS].pos;
         cl_vel_ff <= car_ff[DIV_BITS].vel;
         cl_vtx_ff <= car_ff[DIV_BITS].vtx;
      end
   end

   // time times velocity
   logic        tm_ok_ff;
   logic [30:0] tm_t_ff;
   vec3_type    tm_tv_ff, tm_tv_in, tm_pos_ff;
   quad_type    tm_vtx_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tm_tv_in[i] = fmul({1'b0, cl_t_ff}, cl_vel_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_TMUL]) begin
         tm_ok_ff  <= cl_ok_ff;
         tm_t_ff   <= cl_t_ff;
         tm_tv_ff  <= tm_tv_in;
         tm_pos_ff <= cl_pos_ff;
         tm_vtx_ff <= cl_vtx_ff;
      end
   end

   // projected point
   logic        pj_ok_ff;
   logic [30:0] pj_t_ff;
   vec3_type    pj_p_ff, pj_p_in;
   quad_type    pj_vtx_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pj_p_in[i] = tm_pos_ff[i] + tm_tv_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PROJ]) begin
         pj_ok_ff  <= tm_ok_ff;
         pj_t_ff   <= tm_t_ff;
         pj_p_ff   <= pj_p_in;
         pj_vtx_ff <= tm_vtx_ff;
      end
   end

   // edges and offsets from each vertex
   logic        dl_ok_ff;
   logic [30:0] dl_t_ff;
   vec3_type    dl_p_ff;
   quad_type    dl_e_ff, dl_d_ff, dl_e_in, dl_d_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            dl_e_in[k][i] = pj_vtx_ff[(k+1)%4][i] - pj_vtx_ff[k][i];
            dl_d_in[k][i] = pj_p_ff[i] - pj_vtx_ff[k][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DELTA]) begin
         dl_ok_ff <= pj_ok_ff;
         dl_t_ff  <= pj_t_ff;
         dl_p_ff  <= pj_p_ff;
         dl_e_ff  <= dl_e_in;
         dl_d_ff  <= dl_d_in;
      end
   end

   // cross product terms
   logic        cr_ok_ff;
   logic [30:0] cr_t_ff;
   vec3_type    cr_p_ff;
   quad_type    cr_pos_ff, cr_neg_ff, cr_pos_in, cr_neg_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            cr_pos_in[k][i] = fmul(dl_e_ff[k][(i+1)%3], dl_d_ff[k][(i+2)%3]);
            cr_neg_in[k][i] = fmul(dl_e_ff[k][(i+2)%3], dl_d_ff[k][(i+1)%3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_CROSS]) begin
         cr_ok_ff  <= dl_ok_ff;
         cr_t_ff   <= dl_t_ff;
         cr_p_ff   <= dl_p_ff;
         cr_pos_ff <= cr_pos_in;
         cr_neg_ff <= cr_neg_in;
      end
   end

   // edge normals
   logic        ed_ok_ff;
   logic [30:0] ed_t_ff;
   vec3_type    ed_p_ff;
   quad_type    ed_m_ff, ed_m_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            ed_m_in[k][i] = cr_pos_ff[k][i] - cr_neg_ff[k][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_EDGE]) begin
         ed_ok_ff <= cr_ok_ff;
         ed_t_ff  <= cr_t_ff;
         ed_p_ff  <= cr_p_ff;
         ed_m_ff  <= ed_m_in;
      end
   end

   // first edge normal against the other three
   logic                ds_ok_ff;
   logic [30:0]         ds_t_ff;
   vec3_type            ds_p_ff;
   logic [2:0][2:0][31:0] ds_pr_ff, ds_pr_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            ds_pr_in[j][i] = fmul(ed_m_ff[0][i], ed_m_ff[j+1][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DOT]) begin
         ds_ok_ff <= ed_ok_ff;
         ds_t_ff  <= ed_t_ff;
         ds_p_ff  <= ed_p_ff;
         ds_pr_ff <= ds_pr_in;
      end
   end

   // sign agreement and output register
   logic [2:0]  sgn;
   logic        out_hit_ff, out_proj_ff;
   vec3_type    out_p_ff;
   logic [30:0] out_t_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sgn[j] = 1'(((ds_pr_ff[j][0] + ds_pr_ff[j][1] + ds_pr_ff[j][2]) >> 31));
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_hit_ff  <= ds_ok_ff & (sgn[0] == sgn[1]) & (sgn[0] == sgn[2]);
         out_proj_ff <= ds_ok_ff;
         out_p_ff    <= ds_ok_ff ? ds_p_ff : '0;
         out_t_ff    <= ds_ok_ff ? ds_t_ff : '0;
      end
   end

   assign rsp_bus.valid       = v_ff[NS];
   assign rsp_bus.hit         = out_hit_ff;
   assign rsp_bus.projected   = out_proj_ff;
   assign rsp_bus.proj_x      = out_p_ff[0];
   assign rsp_bus.proj_y      = out_p_ff[1];
   assign rsp_bus.proj_z      = out_p_ff[2];
   assign rsp_bus.time_to_hit = out_t_ff;

`ifndef SYNTHESIS
   a_no_hit_unprojected: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.projected |-> !rsp_bus.hit && (rsp_bus.time_to_hit == '0))
      else $error("hit or time without projection");

   a_time_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.projected |-> rsp_bus.time_to_hit <= max_time_ff)
      else $error("time beyond clamp");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");
`endif

endmodule

@@ rtl/core/sqi_ram.sv @@
module sqi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
